### rtl/core/mm_pkg.sv
package mm_pkg;

  // Fixed sizes of the datapath.
  localparam int unsigned MAX_DIM   = 8;
  localparam int unsigned DIM_W     = $clog2(MAX_DIM);
  localparam int unsigned ADDR_W    = 2 * DIM_W;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OP_W      = 2;
  // A dot product of MAX_DIM full-precision terms needs DIM_W guard bits.
  localparam int unsigned ACC_W     = 2 * DATA_W + DIM_W;

  // Operation codes of an input beat.
  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS    = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_EMIT
  } state_e;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clr;
    logic valid;
  } mac_ctrl_t;

  // Largest usable index for a size register: zero acts as one, and
  // anything above MAX_DIM acts as MAX_DIM.
  function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > CFG_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM - 1);
    end else begin
      r = DIM_W'(v - 1'b1);
    end
    return r;
  endfunction

endpackage

### rtl/core/mm_ram.sv
module mm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/mm_mac.sv
module mm_mac (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mm_pkg::mac_ctrl_t         ctrl_i,
  input  logic [mm_pkg::DATA_W-1:0] a_i,
  input  logic [mm_pkg::DATA_W-1:0] b_i,
  output logic                      busy_o,
  output logic [mm_pkg::DATA_W-1:0] value_o,
  output logic                      sat_o
);
  import mm_pkg::*;

  logic signed [2*DATA_W-1:0] prod_q;
  logic                       prod_vld_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [ACC_W-1:0]    shifted;
  logic [ACC_W-DATA_W:0]      upper;
  logic                       fits;

  // Product stage: one signed multiply per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(a_i) * $signed(b_i);
  end

  // Accumulator stage, cleared at the start of each dot product.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + $signed({{(ACC_W-2*DATA_W){prod_q[2*DATA_W-1]}}, prod_q});
    end
  end

  // Floor shift and saturation of the finished sum.
  always_comb begin
    shifted = acc_q >>> FRAC_BITS;
    upper   = shifted[ACC_W-1:DATA_W-1];
    fits    = (&upper) | ~(|upper);
    sat_o   = ~fits;
    if (fits) begin
      value_o = shifted[DATA_W-1:0];
    end else if (acc_q[ACC_W-1]) begin
      value_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      value_o = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  assign busy_o = prod_vld_q;

endmodule

### rtl/core/matrix_multiply_core.sv
// Fixed-point matrix multiply core, C = A * B, signed Q16.16 elements.
// Input channel (in_valid_i / in_stall_o): each beat carries op, row, column
// and element value. Load beats write one element of A or B; loads outside
// the configured sizes and unused op codes are dropped.
// A compute beat runs the whole product; the input channel stalls until the
// last product element has been placed in the output register.
// Output channel (out_valid_o / out_stall_i): one beat per product element in
// row-major order, last_o marks the final one. The output is a register, so
// a new input beat is taken while the final element still waits.
// For each product element, inner_dim reads of the two element memories feed
// one shared multiplier and accumulator; the sequencer then waits for the
// pipeline to drain and loads the output register. A stalled receiver holds
// the sequencer in its emit step without losing any element.
// Size registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
// the core is idle; the user must keep to this, the core does not enforce it.
// Reset sets all sizes to 8 and empties the pipeline; the element memories
// are not cleared and must be loaded before a compute.
module matrix_multiply_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mm_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mm_pkg::OP_W-1:0]      op_i,
  input  logic [mm_pkg::DIM_W-1:0]     row_index_i,
  input  logic [mm_pkg::DIM_W-1:0]     col_index_i,
  input  logic signed [mm_pkg::DATA_W-1:0] element_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mm_pkg::DIM_W-1:0]     out_row_o,
  output logic [mm_pkg::DIM_W-1:0]     out_col_o,
  output logic signed [mm_pkg::DATA_W-1:0] product_value_o,
  output logic                         saturated_o,
  output logic                         last_o
);
  import mm_pkg::*;

  logic [CFG_W-1:0] a_rows_q, inner_dim_q, b_cols_q;
  logic [DIM_W-1:0] row_last, inner_last, col_last;

  state_e           state_q, state_d;
  logic [DIM_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic             rd_vld_q, rd_vld_d;

  logic             in_accept;
  logic             we_a, we_b;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] rdata_a, rdata_b;

  mac_ctrl_t         mac_ctrl;
  logic              mac_busy;
  logic [DATA_W-1:0] mac_value;
  logic              mac_sat;

  logic              out_load;
  logic              elem_last;
  logic              out_valid_q, out_valid_d;
  logic [DIM_W-1:0]  out_row_q, out_col_q;
  logic [DATA_W-1:0] out_value_q;
  logic              out_sat_q, out_last_q;

  // Size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q    <= CFG_RESET;
      inner_dim_q <= CFG_RESET;
      b_cols_q    <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_A_ROWS:    a_rows_q    <= cfg_wdata_i;
        CFG_INNER_DIM: inner_dim_q <= cfg_wdata_i;
        CFG_B_COLS:    b_cols_q    <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  assign row_last   = dim_last(a_rows_q);
  assign inner_last = dim_last(inner_dim_q);
  assign col_last   = dim_last(b_cols_q);

  // Load decode: writes only land inside the configured sizes.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign waddr      = {row_index_i, col_index_i};
  assign we_a = in_accept && (op_i == OP_LOAD_A) &&
                (row_index_i <= row_last) && (col_index_i <= inner_last);
  assign we_b = in_accept && (op_i == OP_LOAD_B) &&
                (row_index_i <= inner_last) && (col_index_i <= col_last);

  mm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_DIM * MAX_DIM)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .raddr_i ({i_q, k_q}),
    .rdata_o (rdata_a)
  );

  mm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_DIM * MAX_DIM)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .raddr_i ({k_q, j_q}),
    .rdata_o (rdata_b)
  );

  assign mac_ctrl.clr   = (state_q == S_ISSUE) && (k_q == '0);
  assign mac_ctrl.valid = rd_vld_q;

  mm_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .a_i     (rdata_a),
    .b_i     (rdata_b),
    .busy_o  (mac_busy),
    .value_o (mac_value),
    .sat_o   (mac_sat)
  );

  // Sequencer state and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state: issue inner_dim reads, drain, then emit one element.
  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    rd_vld_d  = 1'b0;
    out_load  = 1'b0;
    elem_last = (i_q == row_last) && (j_q == col_last);
    unique case (state_q)
      S_IDLE: begin
        if (in_accept && (op_i == OP_COMPUTE)) begin
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        rd_vld_d = 1'b1;
        if (k_q == inner_last) begin
          state_d = S_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_q && !mac_busy) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          k_d      = '0;
          if (elem_last) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_ISSUE;
            if (j_q == col_last) begin
              j_d = '0;
              i_d = i_q + 1'b1;
            end else begin
              j_d = j_q + 1'b1;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register: holds a beat until the receiver takes it.
  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q   <= i_q;
      out_col_q   <= j_q;
      out_value_q <= mac_value;
      out_sat_q   <= mac_sat;
      out_last_q  <= elem_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign product_value_o = out_value_q;
  assign saturated_o     = out_sat_q;
  assign last_o          = out_last_q;

endmodule
